// ===== sv/lbc_pkg.sv =====
// Shared constants, types and helpers for the linear interpolant B-spline coefficient block.
package lbc_pkg;

	localparam int DIMS       = 3;
	localparam int NUM_COORDS = 4;
	localparam int MAX_ORDER  = 16;
	localparam int SLOT_LIMIT = 16;
	localparam int K_MAX      = (MAX_ORDER < SLOT_LIMIT) ? MAX_ORDER : SLOT_LIMIT;
	localparam int CNT_W      = $clog2(K_MAX);

	localparam int ORDER_W    = 5;
	localparam int STEP_W     = 17;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = STEP_W;

	localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP  = 1'd1;

	localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd4;
	localparam logic [STEP_W-1:0]  STEP_RESET  = 17'd21845;
	localparam logic [STEP_W-1:0]  ONE_Q16     = 17'd65536;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [32:0] diff_t;
	typedef logic [STEP_W-1:0]  weight_t;

	typedef enum logic [1:0] {
		MODE_FIRST,
		MODE_NEXT,
		MODE_SINGLE
	} mode_t;

	// order clamped to [2, K_MAX]
	function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] ord);
		logic [ORDER_W-1:0] k;
		k = ord;
		if (ord < ORDER_W'(2))
			k = ORDER_W'(2);
		else if (ord > ORDER_W'(K_MAX))
			k = ORDER_W'(K_MAX);
		return k;
	endfunction

	// min(a + b, 1.0)
	function automatic weight_t sat_add(input weight_t a, input weight_t b);
		logic [STEP_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > {1'b0, ONE_Q16})
			return ONE_Q16;
		return s[STEP_W-1:0];
	endfunction

endpackage

// ===== sv/lbc_blend.sv =====
// One coordinate lane of the blend: prev + round((w2 * (cur - prev)) / 2^16).
module lbc_blend (
	input  lbc_pkg::coord_t  prev,
	input  lbc_pkg::diff_t   diff,
	input  lbc_pkg::weight_t w2,
	output lbc_pkg::coord_t  coef
);

	logic signed [50:0] prod;
	logic signed [50:0] rnd;

	assign prod = $signed({1'b0, w2}) * diff;
	assign rnd  = prod + 51'sd32768;
	assign coef = prev + $signed(rnd[47:16]);

endmodule

// ===== sv/linear_interp_bspline_coeffs.sv =====
// Top level: streams knots and coefficients of the piecewise linear B-spline interpolant.
// Each point is held in an input register while a counter steps through its results, one per
// cycle unless stalled, into an output register: the first point of a curve gives order
// results, each later point order-1, and a final point one more (a lone final point gives
// one result with status set). Coefficients take one multiply-add per used lane from a
// running weight register. The next point is taken as its predecessor's last result leaves.
module linear_interp_bspline_coeffs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lbc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lbc_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  lbc_pkg::coord_t                      param_value,
	input  lbc_pkg::coord_t                      coord_a,
	input  lbc_pkg::coord_t                      coord_b,
	input  lbc_pkg::coord_t                      coord_c,
	input  lbc_pkg::coord_t                      coord_d,
	input  logic                                 final_point,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output lbc_pkg::coord_t                      knot_value,
	output logic                                 coef_valid,
	output lbc_pkg::coord_t                      coef_a,
	output lbc_pkg::coord_t                      coef_b,
	output lbc_pkg::coord_t                      coef_c,
	output lbc_pkg::coord_t                      coef_d,
	output logic                                 run_end,
	output logic                                 curve_done,
	output logic                                 curve_closed,
	output logic                                 status
);

	// configuration
	logic [lbc_pkg::ORDER_W-1:0] order_q;
	lbc_pkg::weight_t            step_q;

	// curve state
	lbc_pkg::coord_t prev_q  [lbc_pkg::NUM_COORDS];
	lbc_pkg::coord_t first_q [lbc_pkg::NUM_COORDS];
	logic            have_first_q;

	// item under work
	logic                        valid_s1;
	lbc_pkg::mode_t              mode_s1;
	logic                        fin_s1;
	logic                        closed_s1;
	lbc_pkg::coord_t             knot_s1;
	lbc_pkg::coord_t             prev_s1 [lbc_pkg::NUM_COORDS];
	lbc_pkg::diff_t              diff_s1 [lbc_pkg::NUM_COORDS];
	logic [lbc_pkg::CNT_W-1:0]   cnt_q;
	lbc_pkg::weight_t            w2_q;

	// result register
	logic            out_valid_q;
	lbc_pkg::coord_t knot_q;
	logic            coef_valid_q;
	lbc_pkg::coord_t coef_q [lbc_pkg::NUM_COORDS];
	logic            run_end_q;
	logic            done_q;
	logic            closed_q;
	logic            status_q;

	lbc_pkg::coord_t             pt_in [lbc_pkg::NUM_COORDS];
	lbc_pkg::coord_t             blend [lbc_pkg::NUM_COORDS];
	logic [lbc_pkg::ORDER_W-1:0] k;
	logic [lbc_pkg::ORDER_W-1:0] k_m1;
	logic [lbc_pkg::ORDER_W-1:0] k_m2;
	logic [lbc_pkg::CNT_W-1:0]   last_idx;
	logic                        emit;
	logic                        last_emit;
	logic                        accept;
	logic                        closed_in;
	logic                        r_coef_valid;
	logic                        r_run_end;
	logic                        r_done;
	logic                        r_closed;
	logic                        r_status;

	assign pt_in[0] = coord_a;
	assign pt_in[1] = coord_b;
	assign pt_in[2] = coord_c;
	assign pt_in[3] = coord_d;

	assign k    = lbc_pkg::eff_order(order_q);
	assign k_m1 = k - lbc_pkg::ORDER_W'(1);
	assign k_m2 = k - lbc_pkg::ORDER_W'(2);

	always_comb begin
		case (mode_s1)
			lbc_pkg::MODE_FIRST:  last_idx = k_m1[lbc_pkg::CNT_W-1:0];
			lbc_pkg::MODE_NEXT:   last_idx = fin_s1 ? k_m1[lbc_pkg::CNT_W-1:0]
			                                        : k_m2[lbc_pkg::CNT_W-1:0];
			lbc_pkg::MODE_SINGLE: last_idx = '0;
			default:              last_idx = '0;
		endcase
	end

	assign emit      = valid_s1 && (!out_valid_q || out_ready);
	assign last_emit = emit && (cnt_q == last_idx);
	assign in_ready  = !valid_s1 || last_emit;
	assign accept    = in_valid && in_ready;

	always_comb begin
		closed_in = 1'b1;
		for (int j = 0; j < lbc_pkg::DIMS; j++)
			if (first_q[j] != pt_in[j])
				closed_in = 1'b0;
	end

	for (genvar j = 0; j < lbc_pkg::NUM_COORDS; j++) begin : g_lane
		if (j < lbc_pkg::DIMS) begin : g_used
			lbc_blend u_blend (
				.prev (prev_s1[j]),
				.diff (diff_s1[j]),
				.w2   (w2_q),
				.coef (blend[j])
			);
		end else begin : g_unused
			assign blend[j] = '0;
		end
	end

	// flags of the result at the current count
	always_comb begin
		r_coef_valid = 1'b0;
		r_run_end    = 1'b0;
		r_done       = 1'b0;
		r_closed     = 1'b0;
		r_status     = 1'b0;
		case (mode_s1)
			lbc_pkg::MODE_FIRST: begin
				r_coef_valid = (cnt_q == '0);
				r_run_end    = (cnt_q == last_idx);
			end
			lbc_pkg::MODE_NEXT: begin
				if (fin_s1 && cnt_q == k_m1[lbc_pkg::CNT_W-1:0]) begin
					r_run_end = 1'b1;
					r_done    = 1'b1;
					r_closed  = closed_s1;
				end else begin
					r_coef_valid = 1'b1;
					r_run_end    = !fin_s1 && (cnt_q == last_idx);
				end
			end
			lbc_pkg::MODE_SINGLE: begin
				r_run_end = 1'b1;
				r_done    = 1'b1;
				r_status  = 1'b1;
			end
			default: begin
				r_coef_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= lbc_pkg::ORDER_RESET;
			step_q  <= lbc_pkg::STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lbc_pkg::REG_ORDER: order_q <= cfg_data[lbc_pkg::ORDER_W-1:0];
				lbc_pkg::REG_STEP:  step_q  <= cfg_data[lbc_pkg::STEP_W-1:0];
				default:            order_q <= order_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_first_q <= 1'b0;
			for (int j = 0; j < lbc_pkg::NUM_COORDS; j++) begin
				prev_q[j]  <= '0;
				first_q[j] <= '0;
			end
		end else if (accept) begin
			if (!have_first_q) begin
				if (!final_point) begin
					have_first_q <= 1'b1;
					for (int j = 0; j < lbc_pkg::NUM_COORDS; j++) begin
						prev_q[j]  <= pt_in[j];
						first_q[j] <= pt_in[j];
					end
				end
			end else begin
				if (final_point)
					have_first_q <= 1'b0;
				for (int j = 0; j < lbc_pkg::NUM_COORDS; j++)
					prev_q[j] <= pt_in[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			cnt_q    <= '0;
		end else if (last_emit) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else if (emit) begin
			cnt_q <= cnt_q + lbc_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			knot_s1   <= param_value;
			fin_s1    <= final_point;
			closed_s1 <= closed_in;
			w2_q      <= lbc_pkg::sat_add('0, step_q);
			if (!have_first_q)
				mode_s1 <= final_point ? lbc_pkg::MODE_SINGLE : lbc_pkg::MODE_FIRST;
			else
				mode_s1 <= lbc_pkg::MODE_NEXT;
			for (int j = 0; j < lbc_pkg::NUM_COORDS; j++) begin
				if (have_first_q) begin
					prev_s1[j] <= prev_q[j];
					diff_s1[j] <= 33'(pt_in[j]) - 33'(prev_q[j]);
				end else begin
					prev_s1[j] <= pt_in[j];
					diff_s1[j] <= '0;
				end
			end
		end else if (emit) begin
			w2_q <= lbc_pkg::sat_add(w2_q, step_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			knot_q       <= knot_s1;
			coef_valid_q <= r_coef_valid;
			run_end_q    <= r_run_end;
			done_q       <= r_done;
			closed_q     <= r_closed;
			status_q     <= r_status;
			for (int j = 0; j < lbc_pkg::NUM_COORDS; j++)
				coef_q[j] <= r_coef_valid ? blend[j] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign knot_value   = knot_q;
	assign coef_valid   = coef_valid_q;
	assign coef_a       = coef_q[0];
	assign coef_b       = coef_q[1];
	assign coef_c       = coef_q[2];
	assign coef_d       = coef_q[3];
	assign run_end      = run_end_q;
	assign curve_done   = done_q;
	assign curve_closed = closed_q;
	assign status       = status_q;

endmodule
